FILE: src/rv32ie_pkg.sv
// ----------------------------------------------------------------------------
// rv32ie_pkg
// Opcodes, fault codes, memory sizing and the shared ALU for the RV32I core.
// ----------------------------------------------------------------------------
package rv32ie_pkg;

  localparam int DMEM_WORDS = 1024;
  localparam int DMEM_AW    = $clog2(DMEM_WORDS);
  localparam logic [32:0] DMEM_BYTES = 33'(4 * DMEM_WORDS);

  localparam logic [6:0] OP_MASK   = 7'h7F;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_REG    = 7'h33;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;

  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  localparam logic [1:0] SZ_BYTE = 2'd0;
  localparam logic [1:0] SZ_HALF = 2'd1;
  localparam logic [1:0] SZ_WORD = 2'd2;

  typedef enum logic [1:0] {
    FLT_NONE    = 2'd0,
    FLT_ILLEGAL = 2'd1,
    FLT_ALIGN   = 2'd2,
    FLT_RANGE   = 2'd3
  } fault_t;

  function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                      input logic [31:0] a, input logic [31:0] b);
    logic [31:0] r;
    case (f3)
      F3_ADD:  r = alt ? a - b : a + b;
      F3_SLL:  r = a << b[4:0];
      F3_SLT:  r = {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: r = {31'd0, a < b};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

FILE: src/rv32i_instruction_executor_core.sv
// ----------------------------------------------------------------------------
// rv32i_instruction_executor_core
// RV32I executor: one instruction word per request, one result per request.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    in_instruction
// out      output     out_valid / out_ready  out_fetch_pc .. out_fault
// cfg      input      APB, pready tied high  start_address at byte 0
//
// One request per cycle sustained while out_ready is high. An accepted request
// is executed from the input register and moves into the result register once
// that register is free; its result is offered from the result register.
// After reset in_ready stays low while the DMEM_WORDS (1024) data memory words
// are cleared, one word a cycle. A stalled result holds the input register;
// after clearing, in_ready drops only while both are full and out_ready is low.
// ----------------------------------------------------------------------------
module rv32i_instruction_executor_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_fetch_pc,
  output logic [31:0] out_next_pc,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_reg,
  output logic [31:0] out_dest_value,
  output logic        out_mem_written,
  output logic [1:0]  out_fault,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rv32ie_pkg::*;

  logic [31:0] start_address_r;
  logic [31:0] pc_r;
  logic        clr_busy_r;
  logic [DMEM_AW-1:0] clr_idx_r;

  logic        s0_v_r, s2_v_r;
  logic        s2_en, in_acc, ex_go, cfg_we;

  // operand stage
  logic [31:0] s0_a_r, s0_b_r;
  logic [31:0] ins_r, a_s1, b_s1;

  // register file
  logic [31:0] rf_mem [32];
  logic [31:0] rf_vld_r;
  logic        rf_we;
  logic [4:0]  rf_wa;
  logic [31:0] rf_wd;

  // data memory
  logic [31:0] dmem [DMEM_WORDS];
  logic [31:0] rdata_r;

  // result stage
  logic [31:0] s2_pc_r, s2_npc_r, s2_val_r;
  logic        s2_wr_r, s2_mw_r, s2_ld_r;
  logic [4:0]  s2_rd_r;
  logic [1:0]  s2_fault_r, s2_off_r;
  logic [2:0]  s2_f3_r;
  logic [31:0] ld_val, ld_sh;

  // execute
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd, rs1, rs2;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, addr, val, npc, pc4;
  logic        wr, mw, ld, take, alt;
  fault_t      flt;
  logic [3:0]  be;
  logic [31:0] st_data;
  logic [DMEM_AW-1:0] didx;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? start_address_r : 32'd0;
  assign cfg_we = psel & penable & pwrite;

  assign s2_en    = ~s2_v_r | out_ready;
  assign ex_go    = s0_v_r & s2_en;
  assign in_ready = ~clr_busy_r & (~s0_v_r | s2_en);
  assign in_acc   = in_valid & in_ready;

  // load alignment and write-back value
  always_comb begin
    ld_sh = rdata_r >> {s2_off_r, 3'b000};
    case (s2_f3_r[1:0])
      SZ_BYTE: ld_val = s2_f3_r[2] ? {24'd0, ld_sh[7:0]} : {{24{ld_sh[7]}}, ld_sh[7:0]};
      SZ_HALF: ld_val = s2_f3_r[2] ? {16'd0, ld_sh[15:0]} : {{16{ld_sh[15]}}, ld_sh[15:0]};
      default: ld_val = rdata_r;
    endcase
  end

  assign rf_wd = s2_ld_r ? ld_val : s2_val_r;
  assign rf_wa = s2_rd_r;
  assign rf_we = s2_v_r & out_ready & s2_wr_r;

  assign out_valid       = s2_v_r;
  assign out_fetch_pc    = s2_pc_r;
  assign out_next_pc     = s2_npc_r;
  assign out_reg_written = s2_wr_r;
  assign out_dest_reg    = s2_rd_r;
  assign out_dest_value  = s2_wr_r ? rf_wd : 32'd0;
  assign out_mem_written = s2_mw_r;
  assign out_fault       = s2_fault_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r          <= 1'b0;
      s2_v_r          <= 1'b0;
      start_address_r <= 32'd0;
      pc_r            <= 32'd0;
      clr_busy_r      <= 1'b1;
      clr_idx_r       <= '0;
      rf_vld_r        <= 32'd0;
    end else begin
      if (in_acc) s0_v_r <= 1'b1;
      else if (s2_en) s0_v_r <= 1'b0;
      if (s2_en) s2_v_r <= s0_v_r;
      if (cfg_we) begin
        start_address_r <= pwdata;
        pc_r            <= pwdata;
      end else if (ex_go) begin
        pc_r <= npc;
      end
      if (clr_busy_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == DMEM_AW'(DMEM_WORDS - 1)) clr_busy_r <= 1'b0;
      end
      if (rf_we) rf_vld_r[rf_wa] <= 1'b1;
    end
  end

  // register file with write-through and operand snooping while held
  always_ff @(posedge clk) begin
    if (rf_we) rf_mem[rf_wa] <= rf_wd;
    if (in_acc) begin
      ins_r <= in_instruction;
      if (rf_we && rf_wa == in_instruction[19:15]) s0_a_r <= rf_wd;
      else s0_a_r <= rf_vld_r[in_instruction[19:15]] ? rf_mem[in_instruction[19:15]] : 32'd0;
      if (rf_we && rf_wa == in_instruction[24:20]) s0_b_r <= rf_wd;
      else s0_b_r <= rf_vld_r[in_instruction[24:20]] ? rf_mem[in_instruction[24:20]] : 32'd0;
    end else begin
      if (rf_we && rf_wa == ins_r[19:15]) s0_a_r <= rf_wd;
      if (rf_we && rf_wa == ins_r[24:20]) s0_b_r <= rf_wd;
    end
  end

  // execute
  always_comb begin
    op  = ins_r[6:0] & OP_MASK;
    rd  = ins_r[11:7];
    f3  = ins_r[14:12];
    rs1 = ins_r[19:15];
    rs2 = ins_r[24:20];
    f7  = ins_r[31:25];
    a_s1 = (s2_v_r && s2_wr_r && s2_rd_r == rs1) ? rf_wd : s0_a_r;
    b_s1 = (s2_v_r && s2_wr_r && s2_rd_r == rs2) ? rf_wd : s0_b_r;
    imm_i = {{20{ins_r[31]}}, ins_r[31:20]};
    imm_s = {{20{ins_r[31]}}, ins_r[31:25], ins_r[11:7]};
    imm_b = {{19{ins_r[31]}}, ins_r[31], ins_r[7], ins_r[30:25], ins_r[11:8], 1'b0};
    imm_j = {{11{ins_r[31]}}, ins_r[31], ins_r[19:12], ins_r[20], ins_r[30:21], 1'b0};
    pc4  = pc_r + 32'd4;
    npc  = pc4;
    wr   = 1'b0;
    mw   = 1'b0;
    ld   = 1'b0;
    val  = 32'd0;
    flt  = FLT_NONE;
    take = 1'b0;
    alt  = 1'b0;
    addr = a_s1 + ((op == OP_STORE) ? imm_s : imm_i);
    case (op)
      OP_LUI: begin
        wr = 1'b1; val = {ins_r[31:12], 12'd0};
      end
      OP_AUIPC: begin
        wr = 1'b1; val = pc_r + {ins_r[31:12], 12'd0};
      end
      OP_JAL: begin
        wr = 1'b1; val = pc4; npc = pc_r + imm_j;
      end
      OP_JALR: begin
        if (f3 != F3_ADD) flt = FLT_ILLEGAL;
        else begin
          wr = 1'b1; val = pc4; npc = (a_s1 + imm_i) & ~32'd1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = a_s1 == b_s1;
          F3_BNE:  take = a_s1 != b_s1;
          F3_BLT:  take = $signed(a_s1) < $signed(b_s1);
          F3_BGE:  take = $signed(a_s1) >= $signed(b_s1);
          F3_BLTU: take = a_s1 < b_s1;
          F3_BGEU: take = a_s1 >= b_s1;
          default: flt = FLT_ILLEGAL;
        endcase
        if (take) npc = pc_r + imm_b;
      end
      OP_LOAD, OP_STORE: begin
        if ((op == OP_LOAD && (f3 inside {3'd3, 3'd6, 3'd7})) ||
            (op == OP_STORE && f3 > 3'd2)) flt = FLT_ILLEGAL;
        else if ((f3[1:0] == SZ_HALF && addr[0]) ||
                 (f3[1:0] == SZ_WORD && addr[1:0] != 2'd0)) flt = FLT_ALIGN;
        else if ({1'b0, addr} >= DMEM_BYTES) flt = FLT_RANGE;
        else if (op == OP_LOAD) begin
          wr = 1'b1; ld = 1'b1;
        end else mw = 1'b1;
      end
      OP_IMM: begin
        if (f3 == F3_SLL && f7 != F7_BASE) flt = FLT_ILLEGAL;
        else if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT) flt = FLT_ILLEGAL;
        else begin
          alt = (f3 == F3_SR) && (f7 == F7_ALT);
          wr  = 1'b1;
          val = alu(f3, alt, a_s1,
                    (f3 == F3_SLL || f3 == F3_SR) ? {27'd0, rs2} : imm_i);
        end
      end
      OP_REG: begin
        if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR)) begin
          wr = 1'b1; val = alu(f3, 1'b1, a_s1, b_s1);
        end else if (f7 == F7_BASE) begin
          wr = 1'b1; val = alu(f3, 1'b0, a_s1, b_s1);
        end else flt = FLT_ILLEGAL;
      end
      default: flt = FLT_ILLEGAL;
    endcase
    if (flt != FLT_NONE) begin
      wr = 1'b0; mw = 1'b0; ld = 1'b0; npc = pc4;
    end
    if (rd == 5'd0) begin
      wr = 1'b0; ld = 1'b0;
    end
    if (!wr) val = 32'd0;
    didx = addr[DMEM_AW+1:2];
    case (f3[1:0])
      SZ_BYTE: be = 4'b0001 << addr[1:0];
      SZ_HALF: be = 4'b0011 << addr[1:0];
      default: be = 4'b1111;
    endcase
    st_data = b_s1 << {addr[1:0], 3'b000};
  end

  // data memory: cleared after reset, byte-lane writes, registered read
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      dmem[clr_idx_r] <= 32'd0;
    end else if (ex_go && mw) begin
      for (int i = 0; i < 4; i++) begin
        if (be[i]) dmem[didx][8*i +: 8] <= st_data[8*i +: 8];
      end
    end
    if (ex_go) rdata_r <= dmem[didx];
  end

  // result register
  always_ff @(posedge clk) begin
    if (ex_go) begin
      s2_pc_r    <= pc_r;
      s2_npc_r   <= npc;
      s2_wr_r    <= wr;
      s2_rd_r    <= wr ? rd : 5'd0;
      s2_val_r   <= val;
      s2_mw_r    <= mw;
      s2_ld_r    <= ld;
      s2_fault_r <= flt;
      s2_f3_r    <= f3;
      s2_off_r   <= addr[1:0];
    end
  end

endmodule
